// ----- rtl/core/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    // Timer width default and threshold register width
    localparam int TIMER_BITS_DEF = 20;
    localparam int CFG_W          = 20;

    // APB register map: register i at byte address 4*i
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_SINGLE_CLICK = 2'd1,
        REG_LONG_CLICK   = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    // Threshold defaults, in ticks
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = CFG_W'(50 * 1000);
    localparam logic [CFG_W-1:0] SINGLE_CLICK_RESET = CFG_W'(350 * 1000);
    localparam logic [CFG_W-1:0] LONG_CLICK_RESET   = CFG_W'(500 * 1000);

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_DEBOUNCE     = 4'd1,
        ST_PRESSED      = 4'd2,
        ST_CLICK_UP     = 4'd3,
        ST_CLICK_IDLE   = 4'd4,
        ST_SINGLE       = 4'd5,
        ST_DBL_DEBOUNCE = 4'd6,
        ST_DOUBLE       = 4'd7,
        ST_LONG         = 4'd8,
        ST_OTHER_UP     = 4'd9
    } t_click_state;

endpackage

`default_nettype wire

// ----- rtl/core/bcc_if.sv -----
// Item channels of the button click classifier: level in, events out.
`timescale 1ns / 1ps
`default_nettype none

interface bcc_in_if;
    logic valid;
    logic ready;
    logic pressed;

    modport source (output valid, output pressed, input ready);
    modport sink   (input valid, input pressed, output ready);
endinterface

interface bcc_out_if;
    logic       valid;
    logic       ready;
    logic       click_event;
    logic       single_click_event;
    logic       double_click_event;
    logic       long_click_event;
    logic       release_event;
    logic [3:0] current_state;

    modport source (
        output valid, output click_event, output single_click_event,
        output double_click_event, output long_click_event,
        output release_event, output current_state, input ready
    );
    modport sink (
        input valid, input click_event, input single_click_event,
        input double_click_event, input long_click_event,
        input release_event, input current_state, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/button_click_classifier_top.sv -----
// Button click classifier: debounced single, double and long click detection.
`timescale 1ns / 1ps
`default_nettype none

// Each input item is one sampled button level for one timer tick. The block
// runs a ten-state click machine (idle, debounce, pressed, click up, click
// idle, single click, double-click debounce, double click, long click, other
// up) with a saturating TIMER_BITS-wide count of ticks since the last state
// change, and returns exactly one result item per input item: one-shot event
// flags for the state just entered plus the new state code. Throughput is one
// item per clock; the result appears in the cycle after the item is accepted,
// held in an output register so a new item is taken whenever that register is
// empty or being drained in the same cycle. The per-tick path is the state
// and counter registers feeding one add and three threshold compares.
// Thresholds (debounce, single click, long click, in ticks) sit on an APB
// port at byte addresses 0x0, 0x4 and 0x8; write them only while the block
// is idle. A threshold of 0 behaves as 1; elapsed ticks stop at
// 2^TIMER_BITS once the count saturates, so a threshold above that is never
// reached.

module button_click_classifier_top #(
    parameter int TIMER_BITS = bcc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [bcc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bcc_pkg::DATA_W-1:0] pwdata,
    output logic      [bcc_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    // item channels
    bcc_in_if.sink                         i_in,
    bcc_out_if.source                      o_out
);
    import bcc_pkg::*;

    // Compare width: wide enough for elapsed (count + 1) and the thresholds
    localparam int CMP_W = (TIMER_BITS + 1 > CFG_W) ? TIMER_BITS + 1 : CFG_W;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_single;
    logic [CFG_W-1:0] r_long;
    logic             w_cfg_wr;
    t_reg_idx         w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_single   <= SINGLE_CLICK_RESET;
            r_long     <= LONG_CLICK_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_DEBOUNCE:     r_debounce <= pwdata[CFG_W-1:0];
                REG_SINGLE_CLICK: r_single   <= pwdata[CFG_W-1:0];
                REG_LONG_CLICK:   r_long     <= pwdata[CFG_W-1:0];
                default: begin
                    // unmapped address: write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DEBOUNCE:     prdata = DATA_W'(r_debounce);
            REG_SINGLE_CLICK: prdata = DATA_W'(r_single);
            REG_LONG_CLICK:   prdata = DATA_W'(r_long);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic w_in_fire;

    // take an item when the result register is free or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    // ---------------- click machine ----------------
    t_click_state          r_state;
    t_click_state          n_state;
    logic [TIMER_BITS-1:0] r_count;
    logic [TIMER_BITS-1:0] n_count;
    logic [CMP_W-1:0]      w_elapsed;
    logic                  w_deb_met;
    logic                  w_single_met;
    logic                  w_long_met;
    logic                  w_down;
    logic                  w_changed;

    assign w_down       = i_in.pressed;
    assign w_elapsed    = CMP_W'(r_count) + CMP_W'(1);
    assign w_deb_met    = w_elapsed >= CMP_W'(r_debounce);
    assign w_single_met = w_elapsed >= CMP_W'(r_single);
    assign w_long_met   = w_elapsed >= CMP_W'(r_long);

    always_comb begin
        case (r_state)
            ST_IDLE:         n_state = w_down ? ST_DEBOUNCE : ST_IDLE;
            ST_DEBOUNCE:     n_state = !w_down ? ST_IDLE :
                                       (w_deb_met ? ST_PRESSED : ST_DEBOUNCE);
            ST_PRESSED:      n_state = !w_down ? ST_CLICK_UP :
                                       (w_long_met ? ST_LONG : ST_PRESSED);
            ST_CLICK_UP:     n_state = ST_CLICK_IDLE;
            ST_CLICK_IDLE:   n_state = w_down ? ST_DBL_DEBOUNCE :
                                       (w_single_met ? ST_SINGLE : ST_CLICK_IDLE);
            ST_SINGLE:       n_state = ST_IDLE;
            ST_DBL_DEBOUNCE: n_state = !w_down ? ST_CLICK_IDLE :
                                       (w_deb_met ? ST_DOUBLE : ST_DBL_DEBOUNCE);
            ST_DOUBLE:       n_state = w_down ? ST_DOUBLE : ST_OTHER_UP;
            ST_LONG:         n_state = w_down ? ST_LONG : ST_OTHER_UP;
            ST_OTHER_UP:     n_state = ST_IDLE;
            default:         n_state = ST_IDLE;
        endcase
    end

    assign w_changed = n_state != r_state;

    // any state change clears the count; otherwise it saturates at all-ones
    always_comb begin
        if (w_changed) begin
            n_count = '0;
        end else if (r_count != '1) begin
            n_count = r_count + TIMER_BITS'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else if (w_in_fire) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // ---------------- result register ----------------
    logic       r_click;
    logic       r_single_ev;
    logic       r_double_ev;
    logic       r_long_ev;
    logic       r_release;
    logic [3:0] r_cur_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_click     <= w_changed && (n_state == ST_PRESSED || n_state == ST_DOUBLE);
            r_single_ev <= w_changed && (n_state == ST_SINGLE);
            r_double_ev <= w_changed && (n_state == ST_DOUBLE);
            r_long_ev   <= w_changed && (n_state == ST_LONG);
            r_release   <= w_changed && (n_state == ST_CLICK_UP ||
                                         n_state == ST_OTHER_UP);
            r_cur_state <= n_state;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.click_event        = r_click;
    assign o_out.single_click_event = r_single_ev;
    assign o_out.double_click_event = r_double_ev;
    assign o_out.long_click_event   = r_long_ev;
    assign o_out.release_event      = r_release;
    assign o_out.current_state      = r_cur_state;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the button click classifier: directed and random level streams.
`timescale 1ns / 1ps

module testbench;
    import bcc_pkg::*;

    localparam int TB_TIMER_BITS = TIMER_BITS_DEF;
    localparam int STALL_LIMIT   = 5000;   // cycles with no channel handshake and no APB select

    // One result item as the block presents it
    typedef struct packed {
        logic         click;
        logic         single;
        logic         dbl;
        logic         lng;
        logic         rel;
        t_click_state state;
    } t_click_result;

    // One queued level sample; fixed rows carry a hand-written result
    typedef struct packed {
        logic          reconfig;
        logic          pressed;
        logic          fixed;
        t_click_result want;
    } t_level_item;

    localparam t_click_result NO_CHECK  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE};
    localparam t_click_result QUIET_IDL = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE};
    localparam t_click_result QUIET_DEB = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_DEBOUNCE};

    logic i_clk;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bcc_in_if  in_ch ();
    bcc_out_if out_ch ();

    button_click_classifier_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Click machine predictor: own copy of thresholds, state and counter
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]         thr_debounce;
    logic [CFG_W-1:0]         thr_single;
    logic [CFG_W-1:0]         thr_long;
    t_click_state             click_model;
    logic [TB_TIMER_BITS-1:0] ticks_model;

    function automatic t_click_result classify_tick(input logic down);
        t_click_state  nxt;
        t_click_result r;
        logic [63:0]   elapsed;
        logic          changed;
        elapsed = 64'(ticks_model) + 64'd1;
        nxt     = click_model;
        case (click_model)
            ST_IDLE: begin
                if (down) nxt = ST_DEBOUNCE;
            end
            ST_DEBOUNCE: begin
                if (!down) nxt = ST_IDLE;
                else if (elapsed >= 64'(thr_debounce)) nxt = ST_PRESSED;
            end
            ST_PRESSED: begin
                if (!down) nxt = ST_CLICK_UP;
                else if (elapsed >= 64'(thr_long)) nxt = ST_LONG;
            end
            ST_CLICK_UP:   nxt = ST_CLICK_IDLE;
            ST_CLICK_IDLE: begin
                if (down) nxt = ST_DBL_DEBOUNCE;
                else if (elapsed >= 64'(thr_single)) nxt = ST_SINGLE;
            end
            ST_SINGLE:     nxt = ST_IDLE;
            ST_DBL_DEBOUNCE: begin
                if (!down) nxt = ST_CLICK_IDLE;
                else if (elapsed >= 64'(thr_debounce)) nxt = ST_DOUBLE;
            end
            ST_DOUBLE, ST_LONG: begin
                if (!down) nxt = ST_OTHER_UP;
            end
            ST_OTHER_UP:   nxt = ST_IDLE;
            default:       nxt = ST_IDLE;
        endcase
        changed = (nxt != click_model);
        if (changed) begin
            click_model = nxt;
            ticks_model = '0;
        end else if (ticks_model != '1) begin
            ticks_model = ticks_model + TB_TIMER_BITS'(1);   // saturates at all ones
        end
        r.click  = changed && (nxt == ST_PRESSED || nxt == ST_DOUBLE);
        r.single = changed && (nxt == ST_SINGLE);
        r.dbl    = changed && (nxt == ST_DOUBLE);
        r.lng    = changed && (nxt == ST_LONG);
        r.rel    = changed && (nxt == ST_CLICK_UP || nxt == ST_OTHER_UP);
        r.state  = click_model;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------
    t_level_item   level_queue[$];
    t_click_result expected_events[$];
    t_level_item   offered;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;
    int            fail_count;
    int            quiet_cycles;

    // Sender: offers queued levels, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (offered.fixed) begin
                    void'(classify_tick(offered.pressed));
                    expected_events.push_back(offered.want);
                end else begin
                    expected_events.push_back(classify_tick(offered.pressed));
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (level_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = level_queue.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.pressed <= offered.pressed;
                end else begin
                    in_ch.valid   <= 1'b0;
                    in_ch.pressed <= 1'($urandom);   // junk while idle
                end
            end
        end
    end

    // Receiver: random back-pressure, long hold-offs on request, result check
    always @(posedge i_clk) begin
        t_click_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $error("result item with nothing expected, state %0d",
                           out_ch.current_state);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (out_ch.click_event !== want.click) begin
                        $error("click_event expected %0d actual %0d",
                               want.click, out_ch.click_event);
                        fail_count++;
                    end
                    if (out_ch.single_click_event !== want.single) begin
                        $error("single_click_event expected %0d actual %0d",
                               want.single, out_ch.single_click_event);
                        fail_count++;
                    end
                    if (out_ch.double_click_event !== want.dbl) begin
                        $error("double_click_event expected %0d actual %0d",
                               want.dbl, out_ch.double_click_event);
                        fail_count++;
                    end
                    if (out_ch.long_click_event !== want.lng) begin
                        $error("long_click_event expected %0d actual %0d",
                               want.lng, out_ch.long_click_event);
                        fail_count++;
                    end
                    if (out_ch.release_event !== want.rel) begin
                        $error("release_event expected %0d actual %0d",
                               want.rel, out_ch.release_event);
                        fail_count++;
                    end
                    if (out_ch.current_state !== want.state) begin
                        $error("current_state expected %0d actual %0d",
                               want.state, out_ch.current_state);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Stall counter for the watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bits above the register width are dropped; unused index ignored
        case (idx)
            REG_DEBOUNCE:     thr_debounce = data[CFG_W-1:0];
            REG_SINGLE_CLICK: thr_single   = data[CFG_W-1:0];
            REG_LONG_CLICK:   thr_long     = data[CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_check(input t_reg_idx idx, input logic [CFG_W-1:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== DATA_W'(want)) begin
            $error("prdata of register %0d expected %0d actual %0d", idx, want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all three thresholds with junk in the upper bits, then read them back
    task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] sgl,
                                  input logic [CFG_W-1:0] lng);
        apb_write(REG_DEBOUNCE,     {12'($urandom), deb});
        apb_write(REG_SINGLE_CLICK, {12'($urandom), sgl});
        apb_write(REG_LONG_CLICK,   {12'($urandom), lng});
        apb_check(REG_DEBOUNCE,     thr_debounce);
        apb_check(REG_SINGLE_CLICK, thr_single);
        apb_check(REG_LONG_CLICK,   thr_long);
    endtask

    // Wait until every queued level has gone in and every result has come out
    task automatic drain_pipeline();
        while (level_queue.size() > 0 || in_ch.valid || expected_events.size() > 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);   // result register is one deep
    endtask

    // Alternating press/release runs with glitches and noise bursts mixed in
    task automatic queue_levels(input int count, input int run_lim);
        t_level_item it;
        logic        lvl;
        int          len;
        int          n;
        it  = '{1'b0, 1'b0, 1'b0, NO_CHECK};
        lvl = 1'b1;
        n   = 0;
        while (n < count) begin
            lvl = ~lvl;
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    it.pressed = 1'($urandom);
                    level_queue.push_back(it);
                end
            end else begin
                len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, run_lim);
                it.pressed = lvl;
                repeat (len) level_queue.push_back(it);
            end
            n += len;
        end
    endtask

    // One random phase; with pressure the receiver holds off for a long stretch,
    // then the sender waits for every result before going on
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] sgl,
                             input logic [CFG_W-1:0] lng, input int count,
                             input logic pressure);
        int lim;
        drain_pipeline();
        set_thresholds(deb, sgl, lng);
        lim = int'(deb);
        if (int'(sgl) > lim) lim = int'(sgl);
        if (int'(lng) > lim) lim = int'(lng);
        lim = lim + 3;
        if (lim > 40) lim = 40;
        if (pressure) begin
            queue_levels(count / 2, lim);
            @(posedge i_clk);
            hold_cycles = 120;
            drain_pipeline();
            queue_levels(count - count / 2, lim);
        end else begin
            queue_levels(count, lim);
        end
    endtask

    t_level_item directed_rows [28];

    initial begin
        t_click_result ck;
        t_click_result rs;
        t_click_result dc;
        t_click_result lc;
        t_click_result dn;
        ck = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ST_PRESSED};
        rs = NO_CHECK;
        dc = NO_CHECK;
        lc = NO_CHECK;
        dn = NO_CHECK;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.pressed   = 1'b0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        fail_count      = 0;
        hold_cycles     = 0;
        send_idle_pct   = 37;
        recv_idle_pct   = 78;
        thr_debounce    = DEBOUNCE_RESET;
        thr_single      = SINGLE_CLICK_RESET;
        thr_long        = LONG_CLICK_RESET;
        click_model     = ST_IDLE;
        ticks_model     = '0;

        // Directed rows. The first three run on the reset thresholds and carry
        // hand-written results; from the reconfig row on, thresholds are
        // debounce 0 (acts as 1), single click 2, long click 4, and the
        // predictor supplies the results.
        directed_rows = '{
            '{1'b0, 1'b0, 1'b1, QUIET_IDL},   // idle stays idle
            '{1'b0, 1'b1, 1'b1, QUIET_DEB},   // press starts debounce
            '{1'b0, 1'b0, 1'b1, QUIET_IDL},   // bounce drops back to idle
            '{1'b1, 1'b1, 1'b0, dn},          // debounce
            '{1'b0, 1'b1, 1'b0, ck},          // zero debounce met at once: click
            '{1'b0, 1'b0, 1'b0, rs},          // click up
            '{1'b0, 1'b0, 1'b0, rs},          // click idle
            '{1'b0, 1'b0, 1'b0, rs},          // still waiting
            '{1'b0, 1'b0, 1'b0, rs},          // single click
            '{1'b0, 1'b0, 1'b0, rs},          // back to idle
            '{1'b0, 1'b1, 1'b0, lc},          // long press from here
            '{1'b0, 1'b1, 1'b0, lc},
            '{1'b0, 1'b1, 1'b0, lc},
            '{1'b0, 1'b1, 1'b0, lc},
            '{1'b0, 1'b1, 1'b0, lc},
            '{1'b0, 1'b1, 1'b0, lc},          // long click
            '{1'b0, 1'b0, 1'b0, lc},          // other up
            '{1'b0, 1'b1, 1'b0, lc},          // other up leaves even if pressed
            '{1'b0, 1'b1, 1'b0, dc},          // double click from here
            '{1'b0, 1'b1, 1'b0, dc},
            '{1'b0, 1'b0, 1'b0, dc},          // click up
            '{1'b0, 1'b1, 1'b0, dc},          // click idle regardless of level
            '{1'b0, 1'b1, 1'b0, dc},          // double-click debounce
            '{1'b0, 1'b0, 1'b0, dc},          // released: back to click idle
            '{1'b0, 1'b1, 1'b0, dc},
            '{1'b0, 1'b1, 1'b0, dc},          // double click
            '{1'b0, 1'b0, 1'b0, dc},          // other up
            '{1'b0, 1'b0, 1'b0, dc}           // idle
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].reconfig) begin
                drain_pipeline();
                apb_write(REG_UNUSED, $urandom);   // unused index: no effect
                set_thresholds(20'd0, 20'd2, 20'd4);
            end
            level_queue.push_back(directed_rows[i]);
        end

        // Sender idles 37 %, receiver 78 %
        run_phase(20'd1, 20'd3, 20'd6, 220, 1'b1);
        run_phase(20'd0, 20'd1, 20'd1, 180, 1'b0);

        // Sender idles 78 %, receiver 37 %
        drain_pipeline();
        send_idle_pct = 78;
        recv_idle_pct = 37;
        run_phase(20'd3, 20'd8, 20'd20, 240, 1'b0);
        run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 150, 1'b1);

        // No idling on either side
        drain_pipeline();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)),
                  CFG_W'($urandom_range(1, 16)), 260, 1'b0);

        drain_pipeline();
        repeat (5) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
